// File: hdl/csvls_pkg.sv
// Shared types, character constants and the per-byte quote rule for the
// CSV line field splitter. No dependencies.
package csvls_pkg;

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef enum logic [2:0] {
    KIND_DATA         = 3'd0,
    KIND_FIELD_END    = 3'd1,
    KIND_LINE_OK      = 3'd2,
    KIND_OPEN_QUOTE   = 3'd3,
    KIND_EOL_OVERFLOW = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_BYTE,
    BK_FIELD_END,
    BK_STATUS
  } back_state_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       line_end;
  } in_item_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic inside_quotes;
    logic quote_seen;
    logic field_empty;
  } quote_state_t;

  localparam quote_state_t QUOTE_STATE_RESET = '{
    inside_quotes: 1'b0, quote_seen: 1'b0, field_empty: 1'b1};

  typedef struct packed {
    logic         emit;
    kind_t        kind;
    logic [7:0]   out_byte;
    quote_state_t state;
  } byte_result_t;

  // One character through the quote rules: at most one result.
  function automatic byte_result_t take_byte(input logic [7:0] c, input quote_state_t s);
    byte_result_t r;
    logic         plain;
    r.emit     = 1'b1;
    r.kind     = KIND_DATA;
    r.out_byte = c;
    r.state    = s;
    plain      = 1'b0;
    if (s.inside_quotes) begin
      if (s.quote_seen) begin
        r.state.quote_seen = 1'b0;
        if (c == CH_QUOTE) begin
          r.state.field_empty = 1'b0;
        end else begin
          // single quote closed the quoted part; byte handled as plain
          r.state.inside_quotes = 1'b0;
          plain = 1'b1;
        end
      end else if (c == CH_QUOTE) begin
        r.state.quote_seen = 1'b1;
        r.emit = 1'b0;
      end else begin
        r.state.field_empty = 1'b0;
      end
    end else begin
      plain = 1'b1;
    end
    if (plain) begin
      if (c == CH_COMMA) begin
        r.kind = KIND_FIELD_END;
        r.out_byte = 8'h00;
        r.state.field_empty = 1'b1;
      end else if (c == CH_QUOTE && s.field_empty) begin
        r.state.inside_quotes = 1'b1;
        r.emit = 1'b0;
      end else begin
        r.state.field_empty = 1'b0;
      end
    end
    return r;
  endfunction

endpackage

// File: hdl/csv_line_field_splitter.sv
// Top level of the CSV line field splitter: front, command queue, back.
// Depends on csvls_pkg, csvls_front, csvls_queue and csvls_back.
//
//  channel | direction | payload    | transfer when
//  in      | input     | in_item_t  | in_valid && in_ready
//  out     | output    | out_item_t | out_valid && out_ready
//
// A CR or LF byte is absorbed by the front with no result.
// In the back, a content byte replays its held CR/LF bytes, then runs
// itself; a line end gives a field end, then a status.
// Unless its output stalls, the back runs one byte per cycle through the
// quote rules; a two-entry queue lets the front take bytes while the back
// replays or stalls. Synchronous reset clears the held count, quote state,
// queue and output. in_ready drops only while the queue is full.
module csv_line_field_splitter
  import csvls_pkg::*;
#(
  parameter int HELD_EOL_MAX = 8
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  localparam int CNT_W = $clog2(HELD_EOL_MAX + 1);
  localparam int Q_W   = 2 + 8 + CNT_W + HELD_EOL_MAX;

  logic                    f_valid;
  logic                    f_ready;
  logic                    f_end;
  logic                    f_ovf;
  logic [7:0]              f_byte;
  logic [CNT_W-1:0]        f_cnt;
  logic [HELD_EOL_MAX-1:0] f_kinds;
  logic [Q_W-1:0]          q_in;
  logic [Q_W-1:0]          q_out;
  logic                    b_valid;
  logic                    b_ready;

  csvls_front #(.HELD_EOL_MAX(HELD_EOL_MAX)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd_end   (f_end),
    .cmd_ovf   (f_ovf),
    .cmd_byte  (f_byte),
    .cmd_cnt   (f_cnt),
    .cmd_kinds (f_kinds)
  );

  assign q_in = {f_end, f_ovf, f_byte, f_cnt, f_kinds};

  csvls_queue #(.WIDTH(Q_W)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (q_in),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (q_out)
  );

  csvls_back #(.HELD_EOL_MAX(HELD_EOL_MAX)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (b_valid),
    .cmd_ready (b_ready),
    .cmd_end   (q_out[Q_W-1]),
    .cmd_ovf   (q_out[Q_W-2]),
    .cmd_byte  (q_out[Q_W-3 -: 8]),
    .cmd_cnt   (q_out[HELD_EOL_MAX +: CNT_W]),
    .cmd_kinds (q_out[HELD_EOL_MAX-1:0]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

`ifndef SYNTHESIS
  a_status_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.kind == KIND_LINE_OK || out_item.kind == KIND_OPEN_QUOTE ||
                  out_item.kind == KIND_EOL_OVERFLOW) |-> out_item.last)
    else $error("line status result without last");

  a_mark_byte_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.kind != KIND_DATA |-> out_item.out_byte == 8'h00)
    else $error("non-data result carries a byte");

  a_out_held_while_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while waiting for transfer");

  a_cmd_push_in_order: assert property (@(posedge clk) disable iff (rst)
    f_valid |-> in_valid && in_ready)
    else $error("command issued without an input transfer");
`endif

endmodule

// File: hdl/csvls_front.sv
// Front part: accepts input items, holds trailing CR/LF bytes and issues
// one command per content byte or line end. Depends on csvls_pkg.
module csvls_front
  import csvls_pkg::*;
#(
  parameter int HELD_EOL_MAX = 8,
  localparam int CNT_W = $clog2(HELD_EOL_MAX + 1),
  localparam int IDX_W = (HELD_EOL_MAX > 1) ? $clog2(HELD_EOL_MAX) : 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  in_item_t                in_item,
  output logic                    cmd_valid,
  input  logic                    cmd_ready,
  output logic                    cmd_end,
  output logic                    cmd_ovf,
  output logic [7:0]              cmd_byte,
  output logic [CNT_W-1:0]        cmd_cnt,
  output logic [HELD_EOL_MAX-1:0] cmd_kinds
);

  logic [HELD_EOL_MAX-1:0] held_kinds;
  logic [CNT_W-1:0]        held_cnt;
  logic                    overflowed;
  logic                    is_eol;
  logic                    take;

  assign is_eol   = !in_item.line_end &&
                    (in_item.data_byte == CH_CR || in_item.data_byte == CH_LF);
  assign in_ready = cmd_ready;
  assign take     = in_valid && in_ready;

  assign cmd_valid = take && !is_eol;
  assign cmd_end   = in_item.line_end;
  assign cmd_ovf   = overflowed;
  assign cmd_byte  = in_item.data_byte;
  assign cmd_cnt   = held_cnt;
  assign cmd_kinds = held_kinds;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_cnt   <= '0;
      overflowed <= 1'b0;
    end else if (take) begin
      if (in_item.line_end) begin
        held_cnt   <= '0;
        overflowed <= 1'b0;
      end else if (is_eol) begin
        if (held_cnt < CNT_W'(HELD_EOL_MAX)) begin
          held_cnt <= held_cnt + CNT_W'(1);
        end else begin
          overflowed <= 1'b1;
        end
      end else begin
        held_cnt <= '0;
      end
    end
  end

  // held kinds: 1 for CR, 0 for LF; only entries below the count are used
  always_ff @(posedge clk) begin
    if (take && is_eol && held_cnt < CNT_W'(HELD_EOL_MAX)) begin
      held_kinds[held_cnt[IDX_W-1:0]] <= (in_item.data_byte == CH_CR);
    end
  end

endmodule

// File: hdl/csvls_queue.sv
// Two-entry command queue between front and back parts.
// Depends on nothing but its WIDTH parameter.
module csvls_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int DEPTH = 2;

  logic [WIDTH-1:0] mem [DEPTH];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (fill != 2'(DEPTH));
  assign pop_valid  = (fill != 2'd0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      if (do_push && !do_pop) begin
        fill <= fill + 2'd1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_data;
  end

endmodule

// File: hdl/csvls_back.sv
// Back part: replays held CR/LF bytes, runs the quote rules one byte per cycle
// unless the output stalls, drives the result register. Depends on csvls_pkg.
module csvls_back
  import csvls_pkg::*;
#(
  parameter int HELD_EOL_MAX = 8,
  localparam int CNT_W = $clog2(HELD_EOL_MAX + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cmd_valid,
  output logic                    cmd_ready,
  input  logic                    cmd_end,
  input  logic                    cmd_ovf,
  input  logic [7:0]              cmd_byte,
  input  logic [CNT_W-1:0]        cmd_cnt,
  input  logic [HELD_EOL_MAX-1:0] cmd_kinds,
  output logic                    out_valid,
  input  logic                    out_ready,
  output out_item_t               out_item
);

  back_state_t             state;
  back_state_t             state_next;
  quote_state_t            qstate;
  quote_state_t            qstate_next;
  logic                    cur_ovf;
  logic [7:0]              cur_byte;
  logic [CNT_W-1:0]        cur_cnt;
  logic [HELD_EOL_MAX-1:0] cur_kinds;

  byte_result_t            step_res;
  byte_result_t            final_res;
  logic [7:0]              step_char;
  out_item_t               res;
  logic                    step_emit;
  logic                    last_step;
  logic                    step_go;
  logic                    done;
  logic                    load;

  // result of the current step
  always_comb begin
    step_char   = (cur_cnt != '0) ? (cur_kinds[0] ? CH_CR : CH_LF) : cur_byte;
    step_res    = take_byte(step_char, qstate);
    final_res   = take_byte(cur_byte, step_res.state);
    res.kind    = KIND_DATA;
    res.out_byte = 8'h00;
    res.last    = 1'b0;
    step_emit   = 1'b0;
    last_step   = 1'b0;
    qstate_next = qstate;
    case (state)
      BK_BYTE: begin
        step_emit    = step_res.emit;
        res.kind     = step_res.kind;
        res.out_byte = step_res.out_byte;
        // last replay is the last result when the closing byte stays silent
        res.last     = (cur_cnt == '0) ||
                       (cur_cnt == CNT_W'(1) && !final_res.emit);
        qstate_next  = step_res.state;
        last_step    = (cur_cnt == '0);
      end
      BK_FIELD_END: begin
        step_emit = 1'b1;
        res.kind  = KIND_FIELD_END;
        if (qstate.quote_seen) begin
          qstate_next.quote_seen    = 1'b0;
          qstate_next.inside_quotes = 1'b0;
        end
      end
      BK_STATUS: begin
        step_emit   = 1'b1;
        res.last    = 1'b1;
        res.kind    = cur_ovf ? KIND_EOL_OVERFLOW :
                      (qstate.inside_quotes ? KIND_OPEN_QUOTE : KIND_LINE_OK);
        qstate_next = QUOTE_STATE_RESET;
        last_step   = 1'b1;
      end
      default: begin
        step_emit = 1'b0;
      end
    endcase
  end

  assign step_go   = (state != BK_IDLE) && (!step_emit || !out_valid || out_ready);
  assign done      = step_go && last_step;
  assign cmd_ready = (state == BK_IDLE) || done;
  assign load      = cmd_valid && cmd_ready;

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (cmd_valid) state_next = cmd_end ? BK_FIELD_END : BK_BYTE;
      end
      BK_FIELD_END: begin
        if (step_go) state_next = BK_STATUS;
      end
      BK_BYTE, BK_STATUS: begin
        if (done) begin
          if (cmd_valid) begin
            state_next = cmd_end ? BK_FIELD_END : BK_BYTE;
          end else begin
            state_next = BK_IDLE;
          end
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      qstate    <= QUOTE_STATE_RESET;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (step_go) qstate <= qstate_next;
      if (step_go && step_emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step_go && step_emit) out_item <= res;
    if (load) begin
      cur_ovf   <= cmd_ovf;
      cur_byte  <= cmd_byte;
      cur_cnt   <= cmd_cnt;
      cur_kinds <= cmd_kinds;
    end else if (step_go && state == BK_BYTE && cur_cnt != '0) begin
      // advance to the next held byte
      cur_cnt   <= cur_cnt - CNT_W'(1);
      cur_kinds <= cur_kinds >> 1;
    end
  end

endmodule
